>>> hdl/hkre_pkg.sv
// Shared types and constants for the keyboard report event converter.
package hkre_pkg;

    localparam int KEY_SLOTS = 6;
    localparam logic [4:0] EVENT_CAP = 5'd20;
    localparam logic [7:0] PHANTOM_MAX = 8'd3;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_UP = 2'd1;
    localparam logic [1:0] EV_REPEAT = 2'd2;

    localparam logic [1:0] CFG_REPEAT_DELAY = 2'd0;
    localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MAX_EVENTS = 2'd2;

    typedef struct packed {
        logic        poll;
        logic        phantom;
        logic [15:0] time_now;
        logic [7:0]  mods;
        logic [KEY_SLOTS-1:0][7:0] keys;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_mod;
        logic [7:0] code;
        logic [7:0] mods;
        logic       last;
    } t_event;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_MERGE = 5'b00100,
        ST_TAIL  = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

endpackage

>>> hdl/hkre_front.sv
// Front end: accept items, drop bad lengths, compact key slots, queue for the engine.
module hkre_front
    import hkre_pkg::*;
#(
    parameter int REPORT_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_time_now,
    input  logic [6:0]  i_report_length,
    input  logic [7:0]  i_modifier_bits,
    input  logic [7:0]  i_key_1,
    input  logic [7:0]  i_key_2,
    input  logic [7:0]  i_key_3,
    input  logic [7:0]  i_key_4,
    input  logic [7:0]  i_key_5,
    input  logic [7:0]  i_key_6,
    input  logic        i_pop,
    output logic        o_head_valid,
    output t_item       o_head
);

    t_item       r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_item       w_item;
    logic        w_keep;
    logic        w_push;
    logic        w_pop;
    logic [7:0]  w_raw [KEY_SLOTS];
    logic [2:0]  w_n;

    assign w_raw[0] = i_key_1;
    assign w_raw[1] = i_key_2;
    assign w_raw[2] = i_key_3;
    assign w_raw[3] = i_key_4;
    assign w_raw[4] = i_key_5;
    assign w_raw[5] = i_key_6;

    always_comb begin
        w_item          = '0;
        w_item.poll     = i_cmd;
        w_item.time_now = i_time_now;
        w_item.mods     = i_modifier_bits;
        w_item.phantom  = (i_key_1 != 8'd0) && (i_key_1 <= PHANTOM_MAX);
        w_n             = 3'd0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (w_raw[i] != 8'd0) begin
                w_item.keys[w_n] = w_raw[i];
                w_n = w_n + 3'd1;
            end
        end
    end

    assign w_keep       = i_cmd || (i_report_length == 7'(REPORT_BYTES));
    assign o_in_stall   = (r_cnt == 2'd2);
    assign w_push       = i_in_valid && !o_in_stall && w_keep;
    assign o_head_valid = (r_cnt != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |=> (r_cnt != 2'd0) || $past(w_pop))
        else $error("queue lost entries");

endmodule

>>> hdl/hkre_back.sv
// Back end: modifier scan, key merge, repeat timing and event output register.
module hkre_back
    import hkre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_head_valid,
    input  t_item       i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_event      o_out
);

    logic [7:0]  r_delay;
    logic [7:0]  r_interval;
    logic [4:0]  r_max;

    t_state      r_state, n_state;
    t_item       r_it, n_it;
    logic [7:0]  r_prev_keys [KEY_SLOTS];
    logic [7:0]  r_prev_mods, n_prev_mods;
    logic [7:0]  r_held_key, n_held_key;
    logic [7:0]  r_held_mods, n_held_mods;
    logic [15:0] r_press, n_press;
    logic [15:0] r_rep, n_rep;
    logic        r_started, n_started;
    logic [2:0]  r_bit, n_bit;
    logic [2:0]  r_pc, n_pc;
    logic [2:0]  r_pl, n_pl;
    logic        r_scan, n_scan;
    logic [4:0]  r_cnt, n_cnt;
    t_event      r_pend, n_pend;
    logic        r_pend_v, n_pend_v;
    t_event      r_out, n_out;
    logic        r_out_v, n_out_v;
    logic        w_keys_upd;

    logic        w_want;
    t_event      w_ev;
    logic [4:0]  w_cap;
    logic        w_emit;
    logic        w_hold;
    logic        w_out_free;
    logic [7:0]  w_kc;
    logic [7:0]  w_kl;
    logic        w_fire;

    assign w_cap      = (r_max > EVENT_CAP) ? EVENT_CAP : r_max;
    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_emit     = w_want && (r_cnt < w_cap);
    assign w_hold     = w_emit && r_pend_v && !w_out_free;
    assign w_kc       = (r_pc < 3'(KEY_SLOTS)) ? r_it.keys[r_pc] : 8'd0;
    assign w_kl       = (r_pl < 3'(KEY_SLOTS)) ? r_prev_keys[r_pl] : 8'd0;
    assign o_pop      = (r_state == ST_IDLE) && i_head_valid;
    assign o_out_valid = r_out_v;
    assign o_out      = r_out;

    always_comb begin
        w_fire = 1'b0;
        if (r_interval != 8'd0 && r_held_key != 8'd0) begin
            if (!r_started) begin
                w_fire = (i_head.time_now - r_press) >= 16'(r_delay);
            end else begin
                w_fire = (i_head.time_now - r_rep) >= 16'(r_interval);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_it        = r_it;
        n_prev_mods = r_prev_mods;
        n_held_key  = r_held_key;
        n_held_mods = r_held_mods;
        n_press     = r_press;
        n_rep       = r_rep;
        n_started   = r_started;
        n_bit       = r_bit;
        n_pc        = r_pc;
        n_pl        = r_pl;
        n_scan      = r_scan;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_out       = r_out;
        n_out_v     = r_out_v && i_out_stall;
        w_keys_upd  = 1'b0;
        w_want      = 1'b0;
        w_ev        = '0;
        w_ev.mods   = r_it.mods;

        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    n_it = i_head;
                    if (i_head.poll) begin
                        if (w_fire) begin
                            n_rep          = i_head.time_now;
                            n_started      = 1'b1;
                            n_pend.kind    = EV_REPEAT;
                            n_pend.is_mod  = 1'b0;
                            n_pend.code    = r_held_key;
                            n_pend.mods    = r_held_mods;
                            n_pend.last    = 1'b0;
                            n_pend_v       = 1'b1;
                            n_state        = ST_FLUSH;
                        end
                    end else begin
                        n_held_mods = i_head.mods;
                        n_held_key  = 8'd0;
                        n_press     = i_head.time_now;
                        n_rep       = 16'd0;
                        n_started   = 1'b0;
                        n_cnt       = 5'd0;
                        n_bit       = 3'd0;
                        n_state     = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                w_want      = r_it.mods[r_bit] ^ r_prev_mods[r_bit];
                w_ev.kind   = r_it.mods[r_bit] ? EV_DOWN : EV_UP;
                w_ev.is_mod = 1'b1;
                w_ev.code   = 8'd1 << r_bit;
                n_bit       = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_prev_mods = r_it.mods;
                    n_pc        = 3'd0;
                    n_pl        = 3'd0;
                    n_scan      = 1'b0;
                    n_state     = r_it.phantom ? ST_FLUSH : ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (r_pc == 3'(KEY_SLOTS) || r_pl == 3'(KEY_SLOTS)) begin
                    n_state = ST_TAIL;
                end else begin
                    if (w_kc != 8'd0) begin
                        n_held_key = w_kc;
                    end
                    if (w_kc == w_kl) begin
                        n_scan = 1'b0;
                        n_pc   = r_pc + 3'd1;
                        n_pl   = r_pl + 3'd1;
                    end else if (r_scan) begin
                        w_want    = (w_kl != 8'd0);
                        w_ev.kind = EV_UP;
                        w_ev.code = w_kl;
                        n_pl      = r_pl + 3'd1;
                    end else if (w_kl == 8'd0) begin
                        w_want    = 1'b1;
                        w_ev.kind = EV_DOWN;
                        w_ev.code = w_kc;
                        n_pc      = r_pc + 3'd1;
                    end else begin
                        n_scan    = (w_kc != 8'd0);
                        w_want    = 1'b1;
                        w_ev.kind = EV_UP;
                        w_ev.code = w_kl;
                        n_pl      = r_pl + 3'd1;
                    end
                end
            end
            ST_TAIL: begin
                if (r_pc != 3'(KEY_SLOTS) && w_kc != 8'd0) begin
                    n_held_key = w_kc;
                    w_want     = 1'b1;
                    w_ev.kind  = EV_DOWN;
                    w_ev.code  = w_kc;
                    n_pc       = r_pc + 3'd1;
                end else begin
                    w_keys_upd = 1'b1;
                    n_state    = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit && !w_hold) begin
            if (r_pend_v) begin
                n_out      = r_pend;
                n_out.last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_pend   = w_ev;
            n_pend_v = 1'b1;
            n_cnt    = r_cnt + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= 8'd0;
            r_interval <= 8'd0;
            r_max      <= EVENT_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_DELAY:    r_delay    <= i_cfg_data;
                CFG_REPEAT_INTERVAL: r_interval <= i_cfg_data;
                CFG_MAX_EVENTS:      r_max      <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold) begin
            r_it   <= n_it;
            r_bit  <= n_bit;
            r_pc   <= n_pc;
            r_pl   <= n_pl;
            r_pend <= n_pend;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_mods <= 8'd0;
            r_held_key  <= 8'd0;
            r_held_mods <= 8'd0;
            r_press     <= 16'd0;
            r_rep       <= 16'd0;
            r_started   <= 1'b0;
            r_scan      <= 1'b0;
            r_cnt       <= 5'd0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_prev_keys[i] <= 8'd0;
            end
        end else begin
            r_out_v <= n_out_v;
            if (!w_hold) begin
                r_state     <= n_state;
                r_prev_mods <= n_prev_mods;
                r_held_key  <= n_held_key;
                r_held_mods <= n_held_mods;
                r_press     <= n_press;
                r_rep       <= n_rep;
                r_started   <= n_started;
                r_scan      <= n_scan;
                r_cnt       <= n_cnt;
                r_pend_v    <= n_pend_v;
                if (w_keys_upd) begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        r_prev_keys[i] <= r_it.keys[i];
                    end
                end
            end
        end
    end

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v) else $error("pending event left in idle");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= EVENT_CAP) else $error("event count over cap");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MERGE || r_state == ST_TAIL) |->
        ((r_pc <= 3'(KEY_SLOTS)) && (r_pl <= 3'(KEY_SLOTS))))
        else $error("merge pointer out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != ST_MOD) || !$past(i_head.poll))
        else $error("poll entered modifier scan");

endmodule

>>> hdl/hid_keyboard_report_events_top.sv
// Keyboard report to key event converter, top level.
// Input channel: one item per transfer (i_in_valid / o_in_stall). cmd 0 carries a
// boot keyboard report, cmd 1 is a typematic repeat poll. Reports whose length is
// not the report size are dropped at the front with no event.
// Output channel: one key event per transfer (o_out_valid / i_out_stall); the
// last event of an item has o_last set. An item may produce no event at all.
// A two-entry queue sits between the front and the event engine, so items are
// taken while the engine works or the receiver stalls.
// Engine steps: a poll is handled in idle and, when it fires a repeat, goes on to the
// flush; a report starts in idle, scans the eight modifier bits, merges the six key
// slots against the previous report, emits the remaining new keys in the tail and
// ends in the flush. A phantom report skips merge and tail. The engine pops a new
// item from the queue only in idle, so it finishes one item before it takes the next.
// A receiver stall freezes the engine only when a new event has nowhere to go.
// Reset (synchronous, active low) clears the queue, key state, repeat timing and
// registers: repeat_delay 0, repeat_interval 0, max_events 20.
// Configuration writes must be made only while the block is idle; the block itself does not enforce this.
module hid_keyboard_report_events_top
    import hkre_pkg::*;
#(
    parameter int REPORT_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_time_now,
    input  logic [6:0]  i_report_length,
    input  logic [7:0]  i_modifier_bits,
    input  logic [7:0]  i_key_1,
    input  logic [7:0]  i_key_2,
    input  logic [7:0]  i_key_3,
    input  logic [7:0]  i_key_4,
    input  logic [7:0]  i_key_5,
    input  logic [7:0]  i_key_6,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_kind,
    output logic        o_modifier_event,
    output logic [7:0]  o_key_code,
    output logic [7:0]  o_modifiers_now,
    output logic        o_last
);

    t_item  w_head;
    logic   w_head_valid;
    logic   w_pop;
    t_event w_out;

    hkre_front #(
        .REPORT_BYTES(REPORT_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_time_now     (i_time_now),
        .i_report_length(i_report_length),
        .i_modifier_bits(i_modifier_bits),
        .i_key_1        (i_key_1),
        .i_key_2        (i_key_2),
        .i_key_3        (i_key_3),
        .i_key_4        (i_key_4),
        .i_key_5        (i_key_5),
        .i_key_6        (i_key_6),
        .i_pop          (w_pop),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head)
    );

    hkre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_head_valid(w_head_valid),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (w_out)
    );

    assign o_event_kind     = w_out.kind;
    assign o_modifier_event = w_out.is_mod;
    assign o_key_code       = w_out.code;
    assign o_modifiers_now  = w_out.mods;
    assign o_last           = w_out.last;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the keyboard report to key event converter.
module tb;
    import hkre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        cmd;
        logic [15:0] tnow;
        logic [6:0]  len;
        logic [7:0]  mods;
        logic [7:0]  keys [6];
    } t_report;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = CFG_REPEAT_DELAY;
    logic [7:0]  i_cfg_data = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic        i_cmd = 0;
    logic [15:0] i_time_now = 0;
    logic [6:0]  i_report_length = 0;
    logic [7:0]  i_modifier_bits = 0;
    logic [7:0]  i_key_1 = 0, i_key_2 = 0, i_key_3 = 0, i_key_4 = 0, i_key_5 = 0, i_key_6 = 0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    logic [1:0]  o_event_kind;
    logic        o_modifier_event;
    logic [7:0]  o_key_code;
    logic [7:0]  o_modifiers_now;
    logic        o_last;

    hid_keyboard_report_events_top DUT (.*);

    always #6 i_clk = ~i_clk;

    t_report pending_reports [$];
    t_event  expected_events [$];
    int      fails = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      hold_cnt = 0;
    bit      hold_req = 0;
    bit      in_taken = 0;
    int      quiet_cycles = 0;

    // predictor state
    logic [7:0]  delay_r = 0, interval_r = 0;
    logic [4:0]  max_ev_r = 5'd20;
    logic [7:0]  prev_keys [6] = '{default: 0};
    logic [7:0]  prev_mods = 0, held_key = 0, held_mods = 0;
    logic [15:0] press_time = 0, repeat_time = 0;
    bit          repeat_started = 0;
    t_event      ev_buf [20];
    int          ev_n, ev_cap;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    function automatic void add_event(logic [1:0] kind, logic is_mod, logic [7:0] code,
                                      logic [7:0] mods);
        if (ev_n < ev_cap) begin
            ev_buf[ev_n] = '{kind: kind, is_mod: is_mod, code: code, mods: mods, last: 1'b0};
            ev_n++;
        end
    endfunction

    function automatic void predict_events(t_report r);
        logic [7:0]  cur [6];
        logic [7:0]  b, kc, kl;
        logic [15:0] dt;
        int          n, pc, pl;
        ev_n = 0;
        ev_cap = 20;
        if (r.cmd) begin
            if (interval_r == 0 || held_key == 0) return;
            dt = repeat_started ? r.tnow - repeat_time : r.tnow - press_time;
            if (dt < (repeat_started ? interval_r : delay_r)) return;
            repeat_time = r.tnow;
            repeat_started = 1;
            expected_events.push_back('{kind: EV_REPEAT, is_mod: 1'b0, code: held_key,
                                        mods: held_mods, last: 1'b1});
            return;
        end
        if (r.len != 7'd8) return;
        ev_cap = (max_ev_r > EVENT_CAP) ? EVENT_CAP : max_ev_r;
        held_mods = r.mods;
        held_key = 0;
        press_time = r.tnow;
        repeat_time = 0;
        repeat_started = 0;
        for (int i = 0; i < 8; i++) begin
            b = 8'(1 << i);
            if ((r.mods & b) != (prev_mods & b))
                add_event((r.mods & b) != 0 ? EV_DOWN : EV_UP, 1'b1, b, r.mods);
        end
        prev_mods = r.mods;
        if (!(r.keys[0] != 0 && r.keys[0] <= PHANTOM_MAX)) begin
            n = 0;
            for (int i = 0; i < 6; i++) cur[i] = 0;
            for (int i = 0; i < 6; i++)
                if (r.keys[i] != 0) begin
                    cur[n] = r.keys[i];
                    n++;
                end
            pc = 0;
            pl = 0;
            while (pl < 6 && pc < 6) begin
                kc = cur[pc];
                kl = prev_keys[pl];
                if (kc != 0) held_key = kc;
                if (kc == kl) begin
                    pc++;
                    pl++;
                end else if (kc != 0 && kl == 0) begin
                    add_event(EV_DOWN, 1'b0, kc, r.mods);
                    pc++;
                end else if (kc == 0) begin
                    add_event(EV_UP, 1'b0, kl, r.mods);
                    pl++;
                end else begin
                    while (pl < 6 && prev_keys[pl] != kc) begin
                        if (prev_keys[pl] != 0) add_event(EV_UP, 1'b0, prev_keys[pl], r.mods);
                        pl++;
                    end
                end
            end
            while (pc < 6 && cur[pc] != 0) begin
                held_key = cur[pc];
                add_event(EV_DOWN, 1'b0, cur[pc], r.mods);
                pc++;
            end
            for (int i = 0; i < 6; i++) prev_keys[i] = cur[i];
        end
        for (int i = 0; i < ev_n; i++) begin
            ev_buf[i].last = (i == ev_n - 1);
            expected_events.push_back(ev_buf[i]);
        end
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_reports.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_report r;
                r = pending_reports.pop_front();
                i_in_valid <= 1;
                i_cmd <= r.cmd;
                i_time_now <= r.tnow;
                i_report_length <= r.len;
                i_modifier_bits <= r.mods;
                i_key_1 <= r.keys[0];
                i_key_2 <= r.keys[1];
                i_key_3 <= r.keys[2];
                i_key_4 <= r.keys[3];
                i_key_5 <= r.keys[4];
                i_key_6 <= r.keys[5];
            end else begin
                i_in_valid <= 0;
            end
        end
        i_out_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req) begin
            hold_cnt <= 400;
            hold_req <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            t_report r;
            r.cmd = i_cmd;
            r.tnow = i_time_now;
            r.len = i_report_length;
            r.mods = i_modifier_bits;
            r.keys = '{i_key_1, i_key_2, i_key_3, i_key_4, i_key_5, i_key_6};
            predict_events(r);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch("event with none expected");
            end else begin
                t_event e;
                e = expected_events.pop_front();
                if (o_event_kind !== e.kind)
                    report_mismatch($sformatf("kind %0d exp %0d", o_event_kind, e.kind));
                if (o_modifier_event !== e.is_mod)
                    report_mismatch($sformatf("modifier_event %0b exp %0b", o_modifier_event,
                                              e.is_mod));
                if (o_key_code !== e.code)
                    report_mismatch($sformatf("key_code %0h exp %0h", o_key_code, e.code));
                if (o_modifiers_now !== e.mods)
                    report_mismatch($sformatf("modifiers %0h exp %0h", o_modifiers_now, e.mods));
                if (o_last !== e.last)
                    report_mismatch($sformatf("last %0b exp %0b", o_last, e.last));
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    logic [15:0] tick = 0;
    logic [7:0]  gen_mods = 0;

    function automatic t_report make_item(logic cmd, logic [7:0] mods, logic [7:0] k0,
                                          logic [7:0] k1, logic [7:0] k2, logic [7:0] k3,
                                          logic [7:0] k4, logic [7:0] k5);
        t_report r;
        r.cmd = cmd;
        r.tnow = tick;
        r.len = 7'd8;
        r.mods = mods;
        r.keys = '{k0, k1, k2, k3, k4, k5};
        return r;
    endfunction

    function automatic t_report random_item();
        t_report r;
        int roll;
        roll = $urandom_range(99);
        tick = ($urandom_range(99) < 3) ? 16'($urandom) : tick + 16'($urandom_range(0, 6));
        if ($urandom_range(99) < 40) gen_mods = 8'($urandom);
        r = make_item(roll < 30, gen_mods, 0, 0, 0, 0, 0, 0);
        if (roll >= 30) begin
            for (int i = 0; i < 6; i++) begin
                if ($urandom_range(99) < 35) r.keys[i] = 0;
                else if ($urandom_range(99) < 10) r.keys[i] = 8'($urandom);
                else r.keys[i] = 8'(4 + $urandom_range(0, 7));
            end
            if ($urandom_range(99) < 6) r.keys[0] = 8'($urandom_range(1, 3));
            if ($urandom_range(99) < 6) r.len = 7'($urandom);
        end else if ($urandom_range(99) < 20) begin
            r.len = 7'($urandom);
            r.mods = 8'($urandom);
            for (int i = 0; i < 6; i++) r.keys[i] = 8'($urandom);
        end
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_REPEAT_DELAY) delay_r = data;
        else if (idx == CFG_REPEAT_INTERVAL) interval_r = data;
        else max_ev_r = data[4:0];
    endtask

    task automatic drain();
        while (pending_reports.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_phase(int items, int sidle, int stall, logic [7:0] d, logic [7:0] iv,
                             logic [7:0] me);
        write_reg(CFG_REPEAT_DELAY, d);
        write_reg(CFG_REPEAT_INTERVAL, iv);
        write_reg(CFG_MAX_EVENTS, me);
        send_idle_pct = sidle;
        stall_pct = stall;
        for (int i = 0; i < items; i++) pending_reports.push_back(random_item());
        drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        // directed
        pending_reports.push_back(make_item(0, 8'hFF, 4, 5, 6, 7, 8, 9));
        pending_reports.push_back(make_item(0, 8'h00, 10, 11, 12, 13, 14, 15));
        pending_reports.push_back(make_item(1, 8'h00, 0, 0, 0, 0, 0, 0));
        pending_reports.push_back(make_item(0, 8'h55, 0, 11, 0, 20, 0, 8'hFF));
        pending_reports.push_back(make_item(0, 8'hAA, 1, 0, 0, 0, 0, 0));
        pending_reports.push_back(make_item(0, 8'hAA, 2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        pending_reports.push_back(make_item(0, 8'h01, 3, 4, 5, 6, 7, 8));
        pending_reports.push_back(make_item(0, 8'h01, 0, 0, 0, 0, 0, 0));
        begin
            t_report r;
            r = make_item(0, 8'hFF, 4, 5, 6, 7, 8, 9);
            r.len = 7'd7;
            pending_reports.push_back(r);
            r.len = 7'h7F;
            pending_reports.push_back(r);
        end
        drain();
        write_reg(CFG_REPEAT_DELAY, 3);
        write_reg(CFG_REPEAT_INTERVAL, 2);
        write_reg(CFG_MAX_EVENTS, 31);
        for (int i = 0; i < 8; i++) begin
            tick = tick + 2;
            pending_reports.push_back(make_item(i == 0 ? 0 : 1, 8'h10, 9, 0, 0, 0, 0, 0));
        end
        tick = 16'hFFFE;
        pending_reports.push_back(make_item(0, 8'h10, 9, 33, 0, 0, 0, 0));
        tick = 16'h0003;
        pending_reports.push_back(make_item(1, 8'h10, 0, 0, 0, 0, 0, 0));
        drain();
        run_phase(60, 0, 0, 3, 2, 20);
        hold_req = 1;
        run_phase(60, 0, 0, 0, 1, 31);
        run_phase(60, 79, 0, 2, 3, 5);
        run_phase(60, 0, 79, 255, 255, 1);
        run_phase(20, 0, 0, 1, 1, 0);
        run_phase(70, 38, 38, 4, 2, 20);
        run_phase(70, 0, 0, 0, 1, 8'($urandom_range(1, 20)));
        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
